// ===== design/drr_pkg.sv =====
// Shared widths, register indexes and pipeline layout for the depth to radial range block.
package drr_pkg;

   // Field widths
   localparam int DEPTH_W    = 16;
   localparam int COORD_W    = 10;
   localparam int FOCAL_W    = 16;
   localparam int CENTER_W   = 14;
   localparam int RANGE_W    = 16;

   // Configuration port
   localparam int CFG_ADDR_W = 2;
   localparam int CFG_DATA_W = 16;

   localparam logic [CFG_ADDR_W-1:0] REG_FOCAL    = 2'd0;
   localparam logic [CFG_ADDR_W-1:0] REG_CENTER_X = 2'd1;
   localparam logic [CFG_ADDR_W-1:0] REG_CENTER_Y = 2'd2;

   localparam logic [FOCAL_W-1:0]  FOCAL_RESET    = 16'd8400;
   localparam logic [CENTER_W-1:0] CENTER_X_RESET = 14'd5120;
   localparam logic [CENTER_W-1:0] CENTER_Y_RESET = 14'd3840;

   // Stream payloads, packed without gaps and padded to whole bytes
   localparam int REQ_FIELDS_W = DEPTH_W + 2 * COORD_W;
   localparam int REQ_TDATA_W  = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_FIELDS_W = RANGE_W + 1;
   localparam int RSP_TDATA_W  = ((RSP_FIELDS_W + 7) / 8) * 8;

   // Datapath widths
   localparam int OFS_W    = CENTER_W + 1;           // signed pixel offset in Q.4
   localparam int OFS_SQ_W = 2 * CENTER_W;           // squared offset magnitude
   localparam int SQ_W     = 2 * FOCAL_W;            // depth squared, focal squared
   localparam int SUM_W    = SQ_W + 1;               // dx^2 + dy^2 + f^2
   localparam int PROD_W   = SQ_W + SUM_W;           // d^2 * S
   localparam int ROOT_W   = (PROD_W + 1) / 2;       // integer square root
   localparam int RAD_W    = 2 * ROOT_W;             // radicand padded to digit pairs
   localparam int REM_W    = ROOT_W + 2;             // square root partial remainder

   // Pipeline layout
   localparam int SQ_STEPS   = ROOT_W;
   localparam int DIV_STEPS  = RANGE_W;
   localparam int ST_PROD    = 4;
   localparam int ST_SAT     = ST_PROD + SQ_STEPS + 1;
   localparam int NUM_STAGES = ST_SAT + DIV_STEPS + 1;

endpackage

// ===== design/depth_to_radial_range.sv =====
// Top level of the depth to radial range converter: a fully pipelined datapath.
//
// Each request transfer carries one planar depth pixel with its column and row; each
// response transfer carries floor(d * sqrt(dx^2 + dy^2 + f^2) / f), clamped to 65535
// with a saturation flag, where dx and dy are the pixel's signed offsets from the
// principal point and all geometry is in Q.4, unsigned apart from dx and dy. The block
// takes one pixel per clock while req_tready is high and returns one result per pixel,
// in order. The product d^2 * S is fed to a 33-stage bit-per-stage square root,
// followed by one saturation check stage and a 16-stage restoring divider by the
// focal length. A capture stage and four front stages form the offsets, the squares,
// their sum and the wide product. The whole pipeline advances together under one
// enable; a single skid register at the output catches the result that leaves the
// pipeline in the cycle the response side first stalls, so req_tready depends only
// on registered state and drops in the cycle after a stall begins. The focal length
// and principal point are written through the csr port and must only change while
// no pixel is in flight.
module depth_to_radial_range (
   input  logic                                 clock,
   input  logic                                 reset,

   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // Bits from the lowest up: depth_sample[15:0], column[9:0], row_index[9:0], zero pad.
   input  logic [drr_pkg::REQ_TDATA_W-1:0]      req_tdata,

   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // Bits from the lowest up: range_distance[15:0], saturated, zero pad.
   output logic [drr_pkg::RSP_TDATA_W-1:0]      rsp_tdata,

   input  logic                                 csr_wr_en,
   input  logic [drr_pkg::CFG_ADDR_W-1:0]       csr_addr,
   input  logic [drr_pkg::CFG_DATA_W-1:0]       csr_wr_data
);
   import drr_pkg::*;

   // Configuration registers.
   logic [FOCAL_W-1:0]  focal_ff;
   logic [CENTER_W-1:0] center_x_ff;
   logic [CENTER_W-1:0] center_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         focal_ff    <= FOCAL_RESET;
         center_x_ff <= CENTER_X_RESET;
         center_y_ff <= CENTER_Y_RESET;
      end else if (csr_wr_en) begin
         case (csr_addr)
            REG_FOCAL:    focal_ff    <= csr_wr_data[FOCAL_W-1:0];
            REG_CENTER_X: center_x_ff <= csr_wr_data[CENTER_W-1:0];
            REG_CENTER_Y: center_y_ff <= csr_wr_data[CENTER_W-1:0];
            default: ;
         endcase
      end
   end

   // Pipeline control. Every stage moves when the skid register is empty.
   logic                  adv;
   logic [NUM_STAGES-1:0] valid_ff;
   logic [NUM_STAGES-1:0] valid_in;
   logic                  skid_valid_ff;
   logic                  skid_valid_in;

   assign adv        = !skid_valid_ff;
   assign req_tready = adv;
   assign valid_in   = adv ? {valid_ff[NUM_STAGES-2:0], req_tvalid} : valid_ff;

   // The last stage's result is taken directly when the skid is empty. If it is not
   // taken while the pipeline advances, it is parked in the skid register.
   always_comb begin
      skid_valid_in = skid_valid_ff;
      if (skid_valid_ff) begin
         if (rsp_tready) begin
            skid_valid_in = 1'b0;
         end
      end else if (valid_ff[NUM_STAGES-1] && !rsp_tready) begin
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= '0;
         skid_valid_ff <= 1'b0;
      end else begin
         valid_ff      <= valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // Stage 0: capture the request fields.
   logic [DEPTH_W-1:0] depth0_ff;
   logic [COORD_W-1:0] col0_ff;
   logic [COORD_W-1:0] row0_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         depth0_ff <= req_tdata[DEPTH_W-1:0];
         col0_ff   <= req_tdata[DEPTH_W +: COORD_W];
         row0_ff   <= req_tdata[DEPTH_W + COORD_W +: COORD_W];
      end
   end

   // Stage 1: scale the pixel position to Q.4 and subtract the principal point.
   logic [DEPTH_W-1:0]      depth1_ff;
   logic signed [OFS_W-1:0] dx1_ff;
   logic signed [OFS_W-1:0] dy1_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         depth1_ff <= depth0_ff;
         dx1_ff    <= $signed({1'b0, col0_ff, 4'b0000}) - $signed({1'b0, center_x_ff});
         dy1_ff    <= $signed({1'b0, row0_ff, 4'b0000}) - $signed({1'b0, center_y_ff});
      end
   end

   // Stage 2: the four squares.
   logic signed [2*OFS_W-1:0] dx_prod;
   logic signed [2*OFS_W-1:0] dy_prod;
   logic [OFS_SQ_W-1:0]       dx_sq2_ff;
   logic [OFS_SQ_W-1:0]       dy_sq2_ff;
   logic [SQ_W-1:0]           depth_sq2_ff;
   logic [SQ_W-1:0]           focal_sq2_ff;
   logic                      nonzero2_ff;

   assign dx_prod = dx1_ff * dx1_ff;
   assign dy_prod = dy1_ff * dy1_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         dx_sq2_ff    <= dx_prod[OFS_SQ_W-1:0];
         dy_sq2_ff    <= dy_prod[OFS_SQ_W-1:0];
         depth_sq2_ff <= SQ_W'(depth1_ff) * SQ_W'(depth1_ff);
         focal_sq2_ff <= SQ_W'(focal_ff) * SQ_W'(focal_ff);
         nonzero2_ff  <= (depth1_ff != '0);
      end
   end

   // Stage 3: S = dx^2 + dy^2 + f^2 in Q.8.
   logic [SUM_W-1:0] sum3_ff;
   logic [SQ_W-1:0]  depth_sq3_ff;
   logic             nonzero3_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         sum3_ff      <= SUM_W'(dx_sq2_ff) + SUM_W'(dy_sq2_ff) + SUM_W'(focal_sq2_ff);
         depth_sq3_ff <= depth_sq2_ff;
         nonzero3_ff  <= nonzero2_ff;
      end
   end

   // Square root pipeline. Entry 0 is the product stage; entry j+1 holds step j.
   logic [REM_W-1:0]  sq_rem_ff  [SQ_STEPS+1];
   logic [ROOT_W-1:0] sq_root_ff [SQ_STEPS+1];
   logic [RAD_W-1:0]  sq_rad_ff  [SQ_STEPS+1];
   logic              sq_nz_ff   [SQ_STEPS+1];

   always_ff @(posedge clock) begin
      if (adv) begin
         sq_rem_ff[0]  <= '0;
         sq_root_ff[0] <= '0;
         sq_rad_ff[0]  <= RAD_W'(PROD_W'(depth_sq3_ff) * PROD_W'(sum3_ff));
         sq_nz_ff[0]   <= nonzero3_ff;
      end
   end

   // Each step brings down the next pair of radicand bits and tries root*4+1.
   for (genvar j = 0; j < SQ_STEPS; j++) begin : g_sqrt
      logic [REM_W-1:0] rem_sh;
      logic [REM_W-1:0] trial;
      logic             fits;

      assign rem_sh = {sq_rem_ff[j][REM_W-3:0], sq_rad_ff[j][RAD_W-1 -: 2]};
      assign trial  = {sq_root_ff[j], 2'b01};
      assign fits   = (rem_sh >= trial);

      always_ff @(posedge clock) begin
         if (adv) begin
            sq_rem_ff[j+1]  <= fits ? (rem_sh - trial) : rem_sh;
            sq_root_ff[j+1] <= {sq_root_ff[j][ROOT_W-2:0], fits};
            sq_rad_ff[j+1]  <= {sq_rad_ff[j][RAD_W-3:0], 2'b00};
            sq_nz_ff[j+1]   <= sq_nz_ff[j];
         end
      end
   end

   // Divider pipeline. Entry 0 is the saturation stage; entry k+1 holds step k.
   // The result overflows exactly when isqrt(d^2*S) >= f * 65536.
   logic [ROOT_W-1:0]  root_final;
   logic [RANGE_W-1:0] dv_rem_ff [DIV_STEPS+1];
   logic [RANGE_W-1:0] dv_low_ff [DIV_STEPS+1];
   logic [RANGE_W-1:0] dv_quo_ff [DIV_STEPS+1];
   logic               dv_sat_ff [DIV_STEPS+1];
   logic               sat_now;

   assign root_final = sq_root_ff[SQ_STEPS];
   assign sat_now    = sq_nz_ff[SQ_STEPS] &&
                       (root_final[ROOT_W-1:RANGE_W] >= (ROOT_W-RANGE_W)'(focal_ff));

   always_ff @(posedge clock) begin
      if (adv) begin
         dv_rem_ff[0] <= root_final[2*RANGE_W-1:RANGE_W];
         dv_low_ff[0] <= root_final[RANGE_W-1:0];
         dv_quo_ff[0] <= sat_now ? '1 : '0;
         dv_sat_ff[0] <= sat_now;
      end
   end

   // Restoring division by f, one quotient bit per stage. A saturated item keeps an
   // all-ones quotient. With a zero focal length only a zero depth gets this far
   // unsaturated, and its quotient must stay zero.
   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
      logic [RANGE_W:0] rem_sh;
      logic [RANGE_W:0] diff;
      logic             fits;

      assign rem_sh = {dv_rem_ff[k], dv_low_ff[k][RANGE_W-1]};
      assign diff   = rem_sh - {1'b0, focal_ff};
      assign fits   = (focal_ff != '0) && (rem_sh >= {1'b0, focal_ff});

      always_ff @(posedge clock) begin
         if (adv) begin
            dv_rem_ff[k+1] <= fits ? diff[RANGE_W-1:0] : rem_sh[RANGE_W-1:0];
            dv_low_ff[k+1] <= {dv_low_ff[k][RANGE_W-2:0], 1'b0};
            dv_quo_ff[k+1] <= dv_sat_ff[k] ? '1 : {dv_quo_ff[k][RANGE_W-2:0], fits};
            dv_sat_ff[k+1] <= dv_sat_ff[k];
         end
      end
   end

   // Output skid register.
   logic [RANGE_W-1:0] skid_range_ff;
   logic               skid_sat_ff;

   always_ff @(posedge clock) begin
      if (!skid_valid_ff) begin
         skid_range_ff <= dv_quo_ff[DIV_STEPS];
         skid_sat_ff   <= dv_sat_ff[DIV_STEPS];
      end
   end

   assign rsp_tvalid = skid_valid_ff || valid_ff[NUM_STAGES-1];
   assign rsp_tdata  = skid_valid_ff ?
                       {(RSP_TDATA_W-RSP_FIELDS_W)'(0), skid_sat_ff, skid_range_ff} :
                       {(RSP_TDATA_W-RSP_FIELDS_W)'(0), dv_sat_ff[DIV_STEPS],
                        dv_quo_ff[DIV_STEPS]};

endmodule

// ===== design/drr_checker.sv =====
// Port-level assertions for the depth to radial range block, bound to its top level.
module drr_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tready,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [drr_pkg::RSP_TDATA_W-1:0]  rsp_tdata
);
   import drr_pkg::*;

   // A stalled response holds its value until it is taken.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   // A saturated result always carries the clamp value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[RANGE_W] |-> rsp_tdata[RANGE_W-1:0] == '1)
      else $error("saturated result is not clamped");

   // Nothing comes out right after reset.
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("pipeline not empty after reset");

   // The request side is only held off in a cycle that follows a response stall.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tready |=> req_tready)
      else $error("request stalled without a response stall");

   // Back-pressure on the request side means a result is waiting.
   assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("request stalled with no pending result");

endmodule

bind depth_to_radial_range drr_checker u_drr_checker (.*);
